// ----- hdl/ismc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ismc_pkg
// Shared constants, types and helpers for the Ising Metropolis spin update.
// ----------------------------------------------------------------------------
package ismc_pkg;

  // Lattice geometry
  localparam int SIDE   = 64;
  localparam int SIDE_W = (SIDE > 1) ? $clog2(SIDE) : 1;

  // Field widths
  localparam int COL_W   = 6;
  localparam int ROW_W   = 6;
  localparam int RAND_W  = 32;
  localparam int MAG_W   = 14;
  localparam int BOND_W  = 15;
  localparam int THR_W   = 32;
  localparam int ACC_W   = 2 * THR_W;
  localparam int CFG_IDX_W = 3;

  // Threshold registers, one per product value -8, -4, 0, +4, +8
  localparam int NUM_ACCEPT = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_PROD_M8   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROD_M4   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROD_ZERO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROD_P4   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PROD_P8   = 3'd4;

  // Item opcodes
  localparam logic OP_TRIAL = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Neighbor count of four, step of a spin flip, bias of the bond change
  localparam logic [2:0] NBR_COUNT = 3'd4;
  localparam int MAG_STEP  = 2;
  localparam int BOND_BIAS = 8;

  // Reset values of the running sums
  localparam logic signed [MAG_W-1:0]  MAG_RESET  = MAG_W'(SIDE * SIDE);
  localparam logic signed [BOND_W-1:0] BOND_RESET = BOND_W'(2 * SIDE * SIDE);

  // Lattice row to read
  localparam logic [1:0] ROW_UP  = 2'd0;
  localparam logic [1:0] ROW_MID = 2'd1;
  localparam logic [1:0] ROW_DN  = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic       load_item;
    logic [1:0] addr_sel;
    logic       cap_up;
    logic       cap_mid;
    logic       eval;
  } ismc_cmd_t;

  // Fold a coordinate into the lattice
  function automatic logic [SIDE_W-1:0] wrap_coord(input logic [COL_W-1:0] v);
    return SIDE_W'(v % SIDE);
  endfunction

  // Periodic neighbors
  function automatic logic [SIDE_W-1:0] prev_coord(input logic [SIDE_W-1:0] v);
    return (v == '0) ? SIDE_W'(SIDE - 1) : v - 1'b1;
  endfunction

  function automatic logic [SIDE_W-1:0] next_coord(input logic [SIDE_W-1:0] v);
    return (v == SIDE_W'(SIDE - 1)) ? '0 : v + 1'b1;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/ismc_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ismc_ifs
// Channel interfaces: trial items, results and threshold register writes.
// ----------------------------------------------------------------------------
interface ismc_item_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [ismc_pkg::COL_W-1:0] col;
  logic [ismc_pkg::ROW_W-1:0] row;
  logic [ismc_pkg::RAND_W-1:0] rand_word;
  logic                       new_spin;

  modport source (output valid, op, col, row, rand_word, new_spin, input ready);
  modport sink   (input valid, op, col, row, rand_word, new_spin, output ready);
endinterface

interface ismc_result_if;
  logic                              valid;
  logic                              ready;
  logic                              flipped;
  logic                              spin_after;
  logic signed [ismc_pkg::MAG_W-1:0]  mag_total;
  logic signed [ismc_pkg::BOND_W-1:0] bond_total;

  modport source (output valid, flipped, spin_after, mag_total, bond_total, input ready);
  modport sink   (input valid, flipped, spin_after, mag_total, bond_total, output ready);
endinterface

interface ismc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ismc_pkg::CFG_IDX_W-1:0] index;
  logic [ismc_pkg::ACC_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/ismc_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ismc_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ismc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hdl/ismc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ismc_ctrl
// Sequencer: read the rows above, at and below the site, then evaluate and
// write back, and hold the result valid until it is taken.
// ----------------------------------------------------------------------------
module ismc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output ismc_pkg::ismc_cmd_t      cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RD_UP  = 3'd1;
  localparam logic [2:0] ST_RD_MID = 3'd2;
  localparam logic [2:0] ST_RD_DN  = 3'd3;
  localparam logic [2:0] ST_EVAL   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  // Next state and commands
  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.addr_sel  = ismc_pkg::ROW_DN;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = ST_RD_UP;
        end
      end
      ST_RD_UP: begin
        cmd.addr_sel = ismc_pkg::ROW_UP;
        state_next   = ST_RD_MID;
      end
      ST_RD_MID: begin
        cmd.addr_sel = ismc_pkg::ROW_MID;
        cmd.cap_up   = 1'b1;
        state_next   = ST_RD_DN;
      end
      ST_RD_DN: begin
        cmd.addr_sel = ismc_pkg::ROW_DN;
        cmd.cap_mid  = 1'b1;
        state_next   = ST_EVAL;
      end
      ST_EVAL: begin
        // keep the lower row on the read port until the result slot frees
        cmd.addr_sel = ismc_pkg::ROW_DN;
        if (out_free) begin
          cmd.eval   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= cmd.eval || (out_valid && !out_ready);
    end
  end

endmodule
`default_nettype wire

// ----- hdl/ismc_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ismc_datapath
// Lattice row memory with row valid bits, threshold registers, acceptance
// test, row write-back and the running magnetization and bond sums.
// ----------------------------------------------------------------------------
module ismc_datapath (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire ismc_pkg::ismc_cmd_t                  cmd,
  // item payload
  input  wire logic                                 item_op,
  input  wire logic [ismc_pkg::COL_W-1:0]           item_col,
  input  wire logic [ismc_pkg::ROW_W-1:0]           item_row,
  input  wire logic [ismc_pkg::RAND_W-1:0]          item_rand_word,
  input  wire logic                                 item_new_spin,
  // threshold register writes
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [ismc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [ismc_pkg::ACC_W-1:0]           cfg_data,
  // result payload
  output logic                                      flipped,
  output logic                                      spin_after,
  output logic signed [ismc_pkg::MAG_W-1:0]         mag_total,
  output logic signed [ismc_pkg::BOND_W-1:0]        bond_total
);

  localparam int SW = ismc_pkg::SIDE_W;

  logic [ismc_pkg::ACC_W-1:0]  accept_regs [ismc_pkg::NUM_ACCEPT];

  logic                        op;
  logic                        want;
  logic [ismc_pkg::RAND_W-1:0] rnd;
  logic [SW-1:0]               c;
  logic [SW-1:0]               r;
  logic [SW-1:0]               cp;
  logic [SW-1:0]               cn;
  logic [SW-1:0]               rp;
  logic [SW-1:0]               rn;

  logic [SW-1:0]               rd_addr;
  logic [ismc_pkg::SIDE-1:0]   ram_q;
  logic [ismc_pkg::SIDE-1:0]   row_valid;
  logic                        valid_q;
  logic [ismc_pkg::SIDE-1:0]   rd_row;
  logic [ismc_pkg::SIDE-1:0]   up_row;
  logic [ismc_pkg::SIDE-1:0]   mid_row;
  logic [ismc_pkg::SIDE-1:0]   wr_row;

  logic                        s;
  logic [2:0]                  n_up;
  logic [2:0]                  sel;
  logic [ismc_pkg::ACC_W-1:0]  acc_sel;
  logic [ismc_pkg::THR_W-1:0]  thr;
  logic                        flip;
  logic                        spin_new;

  logic signed [ismc_pkg::MAG_W-1:0]  mag_sum;
  logic signed [ismc_pkg::BOND_W-1:0] bond_sum;

  assign cfg_ready = 1'b1;

  // Threshold registers; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ismc_pkg::NUM_ACCEPT; i++) begin
        accept_regs[i] <= '1;
      end
    end else if (cfg_valid && (cfg_index <= ismc_pkg::CFG_PROD_P8)) begin
      accept_regs[cfg_index] <= cfg_data;
    end
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op   <= item_op;
      want <= item_new_spin;
      rnd  <= item_rand_word;
      c    <= ismc_pkg::wrap_coord(item_col);
      r    <= ismc_pkg::wrap_coord(item_row);
    end
  end

  assign cp = ismc_pkg::prev_coord(c);
  assign cn = ismc_pkg::next_coord(c);
  assign rp = ismc_pkg::prev_coord(r);
  assign rn = ismc_pkg::next_coord(r);

  // Row address
  always_comb begin
    unique case (cmd.addr_sel)
      ismc_pkg::ROW_UP:  rd_addr = rp;
      ismc_pkg::ROW_MID: rd_addr = r;
      default:           rd_addr = rn;
    endcase
  end

  ismc_ram #(
    .WIDTH (ismc_pkg::SIDE),
    .DEPTH (ismc_pkg::SIDE)
  ) u_lattice (
    .clk   (clk),
    .we    (cmd.eval),
    .waddr (r),
    .wdata (wr_row),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // Row valid bits: a row never written reads as all spins up
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cmd.eval) begin
      row_valid[r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    valid_q <= row_valid[rd_addr];
  end

  assign rd_row = valid_q ? ram_q : '1;

  // Hold the upper and middle rows
  always_ff @(posedge clk) begin
    if (cmd.cap_up) begin
      up_row <= rd_row;
    end
    if (cmd.cap_mid) begin
      mid_row <= rd_row;
    end
  end

  // Acceptance test; the lower row sits on the read port
  always_comb begin
    s    = mid_row[c];
    n_up = 3'(up_row[c]) + 3'(rd_row[c]) + 3'(mid_row[cp]) + 3'(mid_row[cn]);
    // product 2*s*sum maps to register (product + 8) / 4
    sel     = s ? n_up : (ismc_pkg::NBR_COUNT - n_up);
    acc_sel = accept_regs[sel];
    thr     = s ? acc_sel[ismc_pkg::ACC_W-1:ismc_pkg::THR_W] : acc_sel[ismc_pkg::THR_W-1:0];
    if (op == ismc_pkg::OP_WRITE) begin
      flip = (want != s);
    end else begin
      flip = (thr == '1) || (rnd < thr);
    end
    spin_new  = s ^ flip;
    wr_row    = mid_row;
    wr_row[c] = spin_new;
  end

  // Running sums
  always_ff @(posedge clk) begin
    if (rst) begin
      mag_sum  <= ismc_pkg::MAG_RESET;
      bond_sum <= ismc_pkg::BOND_RESET;
    end else if (cmd.eval && flip) begin
      mag_sum  <= s ? mag_sum - ismc_pkg::MAG_W'(ismc_pkg::MAG_STEP)
                    : mag_sum + ismc_pkg::MAG_W'(ismc_pkg::MAG_STEP);
      bond_sum <= bond_sum + ismc_pkg::BOND_W'(ismc_pkg::BOND_BIAS)
                  - ismc_pkg::BOND_W'({sel, 2'b00});
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      flipped    <= flip;
      spin_after <= spin_new;
    end
  end

  assign mag_total  = mag_sum;
  assign bond_total = bond_sum;

endmodule
`default_nettype wire

// ----- hdl/ising_metropolis_spin_update.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ising_metropolis_spin_update
// Metropolis single-spin update on a periodic square lattice of one-bit
// spins, with running magnetization and bond sums.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  item     in   valid/ready    op, col, row, rand_word, new_spin
//  result   out  valid/ready    flipped, spin_after, mag_total, bond_total
//  cfg      in   valid/ready    index, data (64-bit threshold pair)
//
//  An item goes through accept, three reads of the lattice row memory
//  (row above, site row, row below) on its single read port, then evaluate
//  and write the site row back. A new item is taken once the write is done.
//  The result register holds until taken; a stalled result holds the next
//  item in evaluation. Reset clears the row valid bits at once, so the
//  lattice starts all spins up with no clearing pass. cfg is always ready.
// ----------------------------------------------------------------------------
module ising_metropolis_spin_update (
  input  wire logic     clk,
  input  wire logic     rst,
  ismc_item_if.sink     item,
  ismc_result_if.source result,
  ismc_cfg_if.sink      cfg
);

  ismc_pkg::ismc_cmd_t cmd;

  ismc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd)
  );

  ismc_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .item_op        (item.op),
    .item_col       (item.col),
    .item_row       (item.row),
    .item_rand_word (item.rand_word),
    .item_new_spin  (item.new_spin),
    .cfg_valid      (cfg.valid),
    .cfg_ready      (cfg.ready),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .flipped        (result.flipped),
    .spin_after     (result.spin_after),
    .mag_total      (result.mag_total),
    .bond_total     (result.bond_total)
  );

endmodule
`default_nettype wire

// ----- hdl/ismc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ismc_checker
// Port-level checks on the spin update block, bound to the top level.
// ----------------------------------------------------------------------------
module ismc_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              item_valid,
  input wire logic                              item_ready,
  input wire logic                              res_valid,
  input wire logic                              res_ready,
  input wire logic signed [ismc_pkg::MAG_W-1:0]  mag_total,
  input wire logic signed [ismc_pkg::BOND_W-1:0] bond_total
);

  // One item at a time: no new transfer right after one
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !item_ready)
    else $error("item taken while previous item in work");

  // Spin sum keeps the parity of the site count
  a_mag_parity: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (mag_total[0] == 1'b0))
    else $error("mag_total odd");

  // Every flip moves the bond sum by a multiple of four
  a_bond_step: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (bond_total[1:0] == 2'b00))
    else $error("bond_total not a multiple of four");

  // Stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(mag_total) && $stable(bond_total)))
    else $error("result dropped or changed while stalled");

endmodule

bind ising_metropolis_spin_update ismc_checker u_ismc_checker (
  .clk        (clk),
  .rst        (rst),
  .item_valid (item.valid),
  .item_ready (item.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .mag_total  (result.mag_total),
  .bond_total (result.bond_total)
);
`default_nettype wire
